/* hdl/lcbm_pkg.sv */
`default_nettype none
package lcbm_pkg;

  localparam int MaxPrgBanks = 16;
  localparam int MaxChrBanks = 32;

  localparam int PrgCountW = 5;
  localparam int ChrCountW = 6;
  localparam int PrgBankW  = 4;
  localparam int ChrBankW  = 5;
  localparam int AddrW     = 16;
  localparam int DataW     = 8;
  localparam int MemAddrW  = 17;
  localparam int PaddrW    = 4;
  localparam int PdataW    = 32;

  typedef enum logic [1:0] {
    KIND_CPU_RD = 2'd0,
    KIND_CPU_WR = 2'd1,
    KIND_PPU_RD = 2'd2,
    KIND_PPU_WR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_RAM = 2'd1,
    TGT_PRG_ROM = 2'd2,
    TGT_CHR     = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    REG_PRG_COUNT   = 2'd0,
    REG_CHR_COUNT   = 2'd1,
    REG_CHR_WRITE   = 2'd2,
    REG_INIT_MIRROR = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WAIT,
    ST_DONE
  } state_e;

  // upper nibble of CPU write address selects the register
  localparam logic [3:0] RegSelPrg    = 4'hA;
  localparam logic [3:0] RegSelLowFd  = 4'hB;
  localparam logic [3:0] RegSelLowFe  = 4'hC;
  localparam logic [3:0] RegSelHighFd = 4'hD;
  localparam logic [3:0] RegSelHighFe = 4'hE;
  localparam logic [3:0] RegSelMirror = 4'hF;

  localparam logic [15:0] TileLowFd  = 16'h0FD8;
  localparam logic [15:0] TileLowFe  = 16'h0FE8;
  localparam logic [12:0] TileHighFd = 13'h03FB; // 0x1FD8..0x1FDF, addr[15:3]
  localparam logic [12:0] TileHighFe = 13'h03FD; // 0x1FE8..0x1FEF, addr[15:3]

  typedef struct packed {
    logic [PrgCountW-1:0] prg_count;
    logic [ChrCountW-1:0] chr_count;
    logic                 chr_writable;
    logic                 mirror_load;
    logic                 mirror_value;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [ChrBankW-1:0]  dividend;
    logic [ChrCountW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [ChrBankW-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

/* hdl/lcbm_in_if.sv */
`default_nettype none
interface lcbm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [lcbm_pkg::AddrW-1:0]    bus_address;
  logic [lcbm_pkg::DataW-1:0]    write_value;

  modport source (output valid, output kind, output bus_address, output write_value,
                  input ready);
  modport sink (input valid, input kind, input bus_address, input write_value,
                output ready);
endinterface
`default_nettype wire

/* hdl/lcbm_out_if.sv */
`default_nettype none
interface lcbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    target;
  logic [lcbm_pkg::MemAddrW-1:0] memory_address;
  logic                          memory_write;
  logic [lcbm_pkg::DataW-1:0]    memory_data;
  logic                          mirror_horizontal;

  modport source (output valid, output target, output memory_address,
                  output memory_write, output memory_data, output mirror_horizontal,
                  input ready);
  modport sink (input valid, input target, input memory_address,
                input memory_write, input memory_data, input mirror_horizontal,
                output ready);
endinterface
`default_nettype wire

/* hdl/latched_chr_bank_mapper_core.sv */
// Latched CHR bank mapper core.
// Input channel in_i carries one bus access (kind, bus_address, write_value);
// output channel out_o returns one mapping result per access: target memory,
// byte address, write strobe and data, and the current mirroring bit.
// Both channels transfer on valid && ready. The APB port sets bank counts,
// CHR writability and header mirroring; pready is always high.
// From transfer in to result out, each access passes a decode step, then a
// shared remainder unit that subtracts the bank count once per cycle until the
// remainder is below the count (up to 31 subtractions for CHR, 3 for PRG ROM),
// then the load of the output register. Accesses that need no bank lookup
// skip the unit. in_i.ready is high only while the sequencer is idle, which
// it reaches the cycle after a result is loaded, so no new access is taken
// until the last one's result is in the output register. The output register
// holds a result until taken; a new access may be accepted meanwhile, and its
// result waits in the sequencer while out_o stays stalled.
// Reset clears bank registers, latches (FD) and mirroring, and sets the bank
// counts to 16 PRG and 32 CHR banks.
`default_nettype none
module latched_chr_bank_mapper_core #(
  parameter int MAX_PRG_BANKS = lcbm_pkg::MaxPrgBanks,
  parameter int MAX_CHR_BANKS = lcbm_pkg::MaxChrBanks
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  lcbm_in_if.sink                          in_i,
  lcbm_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lcbm_pkg::PaddrW-1:0] paddr,
  input  wire logic [lcbm_pkg::PdataW-1:0] pwdata,
  output logic      [lcbm_pkg::PdataW-1:0] prdata,
  output logic                             pready
);

  lcbm_pkg::cfg_t     cfg;
  lcbm_pkg::mod_req_t mod_req;
  lcbm_pkg::mod_rsp_t mod_rsp;

  lcbm_pkg::state_e   state_q, state_d;
  lcbm_pkg::target_e  cls_q, cls_d;

  logic [1:0]                      kind_q;
  logic [lcbm_pkg::AddrW-1:0]      addr_q;
  logic [lcbm_pkg::DataW-1:0]      wdata_q;

  logic [lcbm_pkg::PrgBankW-1:0]   prg_sel_q;
  logic [lcbm_pkg::ChrBankW-1:0]   low_fd_q, low_fe_q, high_fd_q, high_fe_q;
  logic                            low_latch_q, high_latch_q, mirror_q;

  logic                            out_valid_q;
  lcbm_pkg::target_e               out_target_q;
  logic [lcbm_pkg::MemAddrW-1:0]   out_addr_q;
  logic                            out_write_q;
  logic [lcbm_pkg::DataW-1:0]      out_data_q;
  logic                            out_mirror_q;

  logic                            accept, commit, is_cpu, reg_write;
  logic                            res_write, res_mirror;
  logic [lcbm_pkg::MemAddrW-1:0]   res_addr;
  logic [lcbm_pkg::ChrBankW-1:0]   chr_bank;
  logic [lcbm_pkg::PrgCountW-1:0]  prg_bank;

  lcbm_cfg_regs #(
    .MAX_PRG_BANKS(MAX_PRG_BANKS),
    .MAX_CHR_BANKS(MAX_CHR_BANKS)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o(cfg)
  );

  lcbm_mod_unit u_mod (
    .clk_i,
    .rst_ni,
    .req_i(mod_req),
    .rsp_o(mod_rsp)
  );

  assign in_i.ready = (state_q == lcbm_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign commit     = (state_q == lcbm_pkg::ST_DONE) && (!out_valid_q || out_o.ready);
  assign is_cpu     = (kind_q == lcbm_pkg::KIND_CPU_RD) || (kind_q == lcbm_pkg::KIND_CPU_WR);
  assign reg_write  = (kind_q == lcbm_pkg::KIND_CPU_WR) && addr_q[15] && (addr_q[14:13] != 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcbm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_i.kind;
      addr_q  <= in_i.bus_address;
      wdata_q <= in_i.write_value;
    end
    if (state_q == lcbm_pkg::ST_DECODE) begin
      cls_q <= cls_d;
    end
  end

  // classify the access and pick the bank to reduce
  always_comb begin
    state_d          = state_q;
    cls_d            = lcbm_pkg::TGT_NONE;
    mod_req.start    = 1'b0;
    mod_req.dividend = '0;
    mod_req.divisor  = {1'b0, cfg.prg_count};
    case (addr_q[14:13])
      2'b01:   prg_bank = cfg.prg_count - lcbm_pkg::PrgCountW'(3);
      2'b10:   prg_bank = cfg.prg_count - lcbm_pkg::PrgCountW'(2);
      2'b11:   prg_bank = cfg.prg_count - lcbm_pkg::PrgCountW'(1);
      default: prg_bank = {1'b0, prg_sel_q};
    endcase
    if (addr_q[12]) chr_bank = high_latch_q ? high_fe_q : high_fd_q;
    else            chr_bank = low_latch_q ? low_fe_q : low_fd_q;
    if (is_cpu) begin
      if (addr_q[15:13] == 3'b011) begin
        cls_d = lcbm_pkg::TGT_PRG_RAM;
      end else if ((kind_q == lcbm_pkg::KIND_CPU_RD) && addr_q[15]) begin
        cls_d = lcbm_pkg::TGT_PRG_ROM;
      end
    end else if ((addr_q[15:13] == 3'b000) &&
                 ((kind_q == lcbm_pkg::KIND_PPU_RD) || cfg.chr_writable)) begin
      cls_d = lcbm_pkg::TGT_CHR;
    end
    case (state_q)
      lcbm_pkg::ST_IDLE: begin
        if (accept) state_d = lcbm_pkg::ST_DECODE;
      end
      lcbm_pkg::ST_DECODE: begin
        if (cls_d == lcbm_pkg::TGT_PRG_ROM) begin
          mod_req.start    = 1'b1;
          mod_req.dividend = prg_bank;
          state_d          = lcbm_pkg::ST_WAIT;
        end else if (cls_d == lcbm_pkg::TGT_CHR) begin
          mod_req.start    = 1'b1;
          mod_req.dividend = chr_bank;
          mod_req.divisor  = cfg.chr_count;
          state_d          = lcbm_pkg::ST_WAIT;
        end else begin
          state_d = lcbm_pkg::ST_DONE;
        end
      end
      lcbm_pkg::ST_WAIT: begin
        if (mod_rsp.done) state_d = lcbm_pkg::ST_DONE;
      end
      lcbm_pkg::ST_DONE: begin
        if (commit) state_d = lcbm_pkg::ST_IDLE;
      end
      default: state_d = lcbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (cls_q)
      lcbm_pkg::TGT_PRG_RAM: res_addr = {4'b0000, addr_q[12:0]};
      lcbm_pkg::TGT_PRG_ROM: res_addr = {mod_rsp.rem[lcbm_pkg::PrgBankW-1:0], addr_q[12:0]};
      lcbm_pkg::TGT_CHR:     res_addr = {mod_rsp.rem, addr_q[11:0]};
      default:               res_addr = '0;
    endcase
    res_write  = ((cls_q == lcbm_pkg::TGT_PRG_RAM) && (kind_q == lcbm_pkg::KIND_CPU_WR)) ||
                 ((cls_q == lcbm_pkg::TGT_CHR) && (kind_q == lcbm_pkg::KIND_PPU_WR));
    res_mirror = (reg_write && (addr_q[15:12] == lcbm_pkg::RegSelMirror)) ? wdata_q[0]
                                                                         : mirror_q;
  end

  // commit updates banks, latches, mirroring; an APB mirroring write wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_sel_q    <= '0;
      low_fd_q     <= '0;
      low_fe_q     <= '0;
      high_fd_q    <= '0;
      high_fe_q    <= '0;
      low_latch_q  <= 1'b0;
      high_latch_q <= 1'b0;
      mirror_q     <= 1'b0;
    end else if (cfg.mirror_load) begin
      mirror_q <= cfg.mirror_value;
    end else if (commit) begin
      mirror_q <= res_mirror;
      if (reg_write) begin
        case (addr_q[15:12])
          lcbm_pkg::RegSelPrg:    prg_sel_q <= wdata_q[lcbm_pkg::PrgBankW-1:0];
          lcbm_pkg::RegSelLowFd:  low_fd_q  <= wdata_q[lcbm_pkg::ChrBankW-1:0];
          lcbm_pkg::RegSelLowFe:  low_fe_q  <= wdata_q[lcbm_pkg::ChrBankW-1:0];
          lcbm_pkg::RegSelHighFd: high_fd_q <= wdata_q[lcbm_pkg::ChrBankW-1:0];
          lcbm_pkg::RegSelHighFe: high_fe_q <= wdata_q[lcbm_pkg::ChrBankW-1:0];
          default: ;
        endcase
      end
      if (cls_q == lcbm_pkg::TGT_CHR) begin
        if (addr_q == lcbm_pkg::TileLowFd)               low_latch_q  <= 1'b0;
        else if (addr_q == lcbm_pkg::TileLowFe)          low_latch_q  <= 1'b1;
        else if (addr_q[15:3] == lcbm_pkg::TileHighFd)   high_latch_q <= 1'b0;
        else if (addr_q[15:3] == lcbm_pkg::TileHighFe)   high_latch_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_target_q <= cls_q;
      out_addr_q   <= res_addr;
      out_write_q  <= res_write;
      out_data_q   <= res_write ? wdata_q : '0;
      out_mirror_q <= res_mirror;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.target            = out_target_q;
  assign out_o.memory_address    = out_addr_q;
  assign out_o.memory_write      = out_write_q;
  assign out_o.memory_data       = out_data_q;
  assign out_o.mirror_horizontal = out_mirror_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcbm_pkg::ST_DONE && out_valid_q && !out_o.ready)
      |=> (state_q == lcbm_pkg::ST_DONE))
    else $error("result left the sequencer while output stalled");

  a_mod_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == lcbm_pkg::ST_WAIT))
    else $error("remainder unit finished outside wait state");

  a_none_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_target_q == lcbm_pkg::TGT_NONE)
      |-> (out_addr_q == '0 && !out_write_q))
    else $error("unmapped access carries address or write");

  a_data_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_write_q) |-> (out_data_q == '0))
    else $error("data byte present without write");

endmodule
`default_nettype wire

/* hdl/lcbm_cfg_regs.sv */
`default_nettype none
module lcbm_cfg_regs #(
  parameter int MAX_PRG_BANKS = lcbm_pkg::MaxPrgBanks,
  parameter int MAX_CHR_BANKS = lcbm_pkg::MaxChrBanks
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lcbm_pkg::PaddrW-1:0]   paddr,
  input  wire logic [lcbm_pkg::PdataW-1:0]   pwdata,
  output logic      [lcbm_pkg::PdataW-1:0]   prdata,
  output logic                               pready,
  output lcbm_pkg::cfg_t                     cfg_o
);

  localparam logic [lcbm_pkg::PrgCountW-1:0] PrgMax = lcbm_pkg::PrgCountW'(MAX_PRG_BANKS);
  localparam logic [lcbm_pkg::ChrCountW-1:0] ChrMax = lcbm_pkg::ChrCountW'(MAX_CHR_BANKS);
  localparam logic [lcbm_pkg::PrgCountW-1:0] PrgMin = lcbm_pkg::PrgCountW'(4);
  localparam logic [lcbm_pkg::ChrCountW-1:0] ChrMin = lcbm_pkg::ChrCountW'(1);

  logic [lcbm_pkg::PrgCountW-1:0] prg_count_q;
  logic [lcbm_pkg::ChrCountW-1:0] chr_count_q;
  logic                           chr_wr_q;
  logic                           init_mirror_q;
  logic                           wr_en;
  lcbm_pkg::reg_idx_e             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lcbm_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= lcbm_pkg::PrgCountW'(16);
      chr_count_q   <= lcbm_pkg::ChrCountW'(32);
      chr_wr_q      <= 1'b0;
      init_mirror_q <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        lcbm_pkg::REG_PRG_COUNT:   prg_count_q   <= pwdata[lcbm_pkg::PrgCountW-1:0];
        lcbm_pkg::REG_CHR_COUNT:   chr_count_q   <= pwdata[lcbm_pkg::ChrCountW-1:0];
        lcbm_pkg::REG_CHR_WRITE:   chr_wr_q      <= pwdata[0];
        lcbm_pkg::REG_INIT_MIRROR: init_mirror_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lcbm_pkg::REG_PRG_COUNT:   prdata = {{(lcbm_pkg::PdataW-lcbm_pkg::PrgCountW){1'b0}},
                                           prg_count_q};
      lcbm_pkg::REG_CHR_COUNT:   prdata = {{(lcbm_pkg::PdataW-lcbm_pkg::ChrCountW){1'b0}},
                                           chr_count_q};
      lcbm_pkg::REG_CHR_WRITE:   prdata = {{(lcbm_pkg::PdataW-1){1'b0}}, chr_wr_q};
      lcbm_pkg::REG_INIT_MIRROR: prdata = {{(lcbm_pkg::PdataW-1){1'b0}}, init_mirror_q};
      default:                   prdata = '0;
    endcase
  end

  // clamp bank counts to the supported range
  always_comb begin
    if (prg_count_q < PrgMin)      cfg_o.prg_count = PrgMin;
    else if (prg_count_q > PrgMax) cfg_o.prg_count = PrgMax;
    else                           cfg_o.prg_count = prg_count_q;
    if (chr_count_q < ChrMin)      cfg_o.chr_count = ChrMin;
    else if (chr_count_q > ChrMax) cfg_o.chr_count = ChrMax;
    else                           cfg_o.chr_count = chr_count_q;
    cfg_o.chr_writable = chr_wr_q;
    cfg_o.mirror_load  = wr_en && (idx == lcbm_pkg::REG_INIT_MIRROR);
    cfg_o.mirror_value = pwdata[0];
  end

endmodule
`default_nettype wire

/* hdl/lcbm_mod_unit.sv */
`default_nettype none
module lcbm_mod_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lcbm_pkg::mod_req_t req_i,
  output lcbm_pkg::mod_rsp_t rsp_o
);

  logic                                busy_q;
  logic [lcbm_pkg::ChrBankW-1:0]       rem_q;
  logic [lcbm_pkg::ChrCountW-1:0]      div_q;
  logic                                ge;

  assign ge = {1'b0, rem_q} >= div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && !ge) begin
      busy_q <= 1'b0;
    end
  end

  // one subtraction per cycle until the remainder drops below the divisor
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q && ge) begin
      rem_q <= rem_q - div_q[lcbm_pkg::ChrBankW-1:0];
    end
  end

  assign rsp_o.done = busy_q && !ge;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

/* tb/sv/lcbm_mapping_checker.sv */
module lcbm_mapping_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lcbm_in_if                          in_i,
  lcbm_out_if                         out_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcbm_pkg::PaddrW-1:0] paddr,
  input  logic [lcbm_pkg::PdataW-1:0] pwdata,
  input  logic                        pready,
  input  logic                        drain_check_i,
  output int                          mismatches_o,
  output int                          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcbm_pkg::*;

  localparam logic [15:0] PrgRamBase = 16'h6000;
  localparam logic [15:0] PrgRomBase = 16'h8000;
  localparam logic [15:0] RegBase    = 16'hA000;
  localparam logic [15:0] PpuTop     = 16'h2000;

  localparam logic [15:0] LowFdTile   = 16'h0FD8;
  localparam logic [15:0] LowFeTile   = 16'h0FE8;
  localparam logic [15:0] HighFdFirst = 16'h1FD8;
  localparam logic [15:0] HighFdLast  = 16'h1FDF;
  localparam logic [15:0] HighFeFirst = 16'h1FE8;
  localparam logic [15:0] HighFeLast  = 16'h1FEF;

  localparam logic [3:0] SelPrg    = 4'hA;
  localparam logic [3:0] SelLowFd  = 4'hB;
  localparam logic [3:0] SelLowFe  = 4'hC;
  localparam logic [3:0] SelHighFd = 4'hD;
  localparam logic [3:0] SelHighFe = 4'hE;

  typedef struct packed {
    target_e               target;
    logic [MemAddrW-1:0]   addr;
    logic                  wr;
    logic [DataW-1:0]      data;
    logic                  mirror;
  } mapping_t;

  // configuration copy
  logic [PrgCountW-1:0] prg_count;
  logic [ChrCountW-1:0] chr_count;
  logic                 chr_wr;

  // mapper state copy
  logic [PrgBankW-1:0]  prg_sel;
  logic [ChrBankW-1:0]  low_fd, low_fe, high_fd, high_fe;
  logic                 low_latch, high_latch;
  logic                 mirror;

  mapping_t expected_q[$];
  int       mismatch_count = 0;
  int       result_count   = 0;
  int       depth          = 0;
  bit       drained        = 1'b0;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = depth;

  function automatic int unsigned prg_banks_used();
    int unsigned n;
    n = prg_count;
    if (n < 4) n = 4;
    if (n > MaxPrgBanks) n = MaxPrgBanks;
    return n;
  endfunction

  function automatic int unsigned chr_banks_used();
    int unsigned n;
    n = chr_count;
    if (n < 1) n = 1;
    if (n > MaxChrBanks) n = MaxChrBanks;
    return n;
  endfunction

  // map one access and advance the state copy
  function automatic mapping_t map_access(kind_e kind, logic [15:0] a, logic [7:0] v);
    mapping_t    r;
    int unsigned n;
    int unsigned bank;
    r = '0;
    r.target = TGT_NONE;
    if (kind == KIND_CPU_RD || kind == KIND_CPU_WR) begin
      if (a >= PrgRamBase && a < PrgRomBase) begin
        r.target = TGT_PRG_RAM;
        r.addr   = MemAddrW'(a - PrgRamBase);
        r.wr     = (kind == KIND_CPU_WR);
      end else if (kind == KIND_CPU_RD && a >= PrgRomBase) begin
        n = prg_banks_used();
        // upper three windows are fixed to the last three banks
        if (a[14:13] == 2'd0) bank = prg_sel;
        else bank = n - 4 + a[14:13];
        r.target = TGT_PRG_ROM;
        r.addr   = MemAddrW'(((bank % n) << 13) + a[12:0]);
      end else if (kind == KIND_CPU_WR && a >= RegBase) begin
        case (a[15:12])
          SelPrg:    prg_sel = v[3:0];
          SelLowFd:  low_fd  = v[4:0];
          SelLowFe:  low_fe  = v[4:0];
          SelHighFd: high_fd = v[4:0];
          SelHighFe: high_fe = v[4:0];
          default:   mirror  = v[0];
        endcase
      end
    end else if (a < PpuTop && (kind == KIND_PPU_RD || chr_wr)) begin
      if (!a[12]) bank = low_latch ? low_fe : low_fd;
      else bank = high_latch ? high_fe : high_fd;
      r.target = TGT_CHR;
      r.addr   = MemAddrW'(((bank % chr_banks_used()) << 12) + a[11:0]);
      r.wr     = (kind == KIND_PPU_WR);
      // latch flips only after the access itself used the old bank
      if (a == LowFdTile) low_latch = 1'b0;
      else if (a == LowFeTile) low_latch = 1'b1;
      else if (a >= HighFdFirst && a <= HighFdLast) high_latch = 1'b0;
      else if (a >= HighFeFirst && a <= HighFeLast) high_latch = 1'b1;
    end
    if (r.wr) r.data = v;
    r.mirror = mirror;
    return r;
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] result %0d, %s: expected %0h, got %0h",
               $time, result_count, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mapping_t want;
    mapping_t got;
    if (!rst_ni) begin
      prg_count  = 5'd16;
      chr_count  = 6'd32;
      chr_wr     = 1'b0;
      prg_sel    = '0;
      low_fd     = '0;
      low_fe     = '0;
      high_fd    = '0;
      high_fe    = '0;
      low_latch  = 1'b0;
      high_latch = 1'b0;
      mirror     = 1'b0;
      expected_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.target = target_e'(out_i.target);
        got.addr   = out_i.memory_address;
        got.wr     = out_i.memory_write;
        got.data   = out_i.memory_data;
        got.mirror = out_i.mirror_horizontal;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result with no access pending: target %0d address %0h",
                     $time, got.target, got.addr);
        end else begin
          want = expected_q.pop_front();
          if (got.target !== want.target) flag("target", want.target, got.target);
          if (got.addr !== want.addr) flag("memory_address", want.addr, got.addr);
          if (got.wr !== want.wr) flag("memory_write", want.wr, got.wr);
          if (got.data !== want.data) flag("memory_data", want.data, got.data);
          if (got.mirror !== want.mirror) flag("mirror_horizontal", want.mirror, got.mirror);
        end
        result_count++;
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_PRG_COUNT:   prg_count = pwdata[PrgCountW-1:0];
          REG_CHR_COUNT:   chr_count = pwdata[ChrCountW-1:0];
          REG_CHR_WRITE:   chr_wr    = pwdata[0];
          REG_INIT_MIRROR: mirror    = pwdata[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready)
        expected_q.push_back(map_access(kind_e'(in_i.kind), in_i.bus_address,
                                        in_i.write_value));
      if (drain_check_i && !drained) begin
        drained = 1'b1;
        if (expected_q.size() != 0) begin
          mismatch_count += expected_q.size();
          $display("[%0t] %0d results never arrived", $time, expected_q.size());
        end
      end
    end
    depth = expected_q.size();
  end

endmodule

/* tb/sv/latched_chr_bank_mapper_core_tb.sv */
module latched_chr_bank_mapper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcbm_pkg::*;

  localparam int PhaseCount   = 7;
  localparam int PhaseItems   = 150;
  localparam int HoldCycles   = 150;
  localparam int SettleCycles = 40;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              drain_check;

  int mismatches;
  int outstanding;
  int accesses = 0;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  lcbm_in_if  in_if ();
  lcbm_out_if out_if ();

  latched_chr_bank_mapper_core u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lcbm_mapping_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_i          (in_if),
    .out_i         (out_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .drain_check_i (drain_check),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    out_if.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk) out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        @(negedge clk) out_if.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        @(negedge clk) out_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [PdataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_setting(input logic [31:0] prg, input logic [31:0] chr,
                              input logic [31:0] wr, input logic [31:0] mir);
    write_reg(REG_PRG_COUNT, prg);
    write_reg(REG_CHR_COUNT, chr);
    write_reg(REG_CHR_WRITE, wr);
    write_reg(REG_INIT_MIRROR, mir);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_access(input kind_e k, input logic [15:0] a, input logic [7:0] v);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk) in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.kind        <= k;
    in_if.bus_address <= a;
    in_if.write_value <= v;
    do @(posedge clk); while (!in_if.ready);
    accesses++;
  endtask

  task automatic release_bus();
    @(negedge clk) in_if.valid <= 1'b0;
  endtask

  // drain all results, then give the sequencer its worst-case latency
  task automatic settle();
    release_bus();
    wait (outstanding == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic send_random();
    kind_e       k;
    logic [15:0] a;
    logic [7:0]  v;
    k = kind_e'(2'($urandom_range(0, 3)));
    v = 8'($urandom);
    case ($urandom_range(0, 9))
      0: a = 16'($urandom);
      1, 2: begin
        // tile fetches on and around the latch triggers
        k = kind_e'(2'($urandom_range(2, 3)));
        case ($urandom_range(0, 3))
          0: a = 16'h0FD8;
          1: a = 16'h0FE8;
          2: a = 16'h1FD8 + 16'($urandom_range(0, 7));
          default: a = 16'h1FE8 + 16'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 3) == 0) a = a + 16'($urandom_range(0, 31)) - 16'd16;
      end
      3, 4, 5: begin
        k = kind_e'(2'($urandom_range(2, 3)));
        a = 16'($urandom_range(0, 16'h1FFF));
      end
      6, 7: begin
        k = KIND_CPU_WR;
        a = {4'($urandom_range(10, 15)), 12'($urandom)};
      end
      default: begin
        k = kind_e'(2'($urandom_range(0, 1)));
        a = 16'($urandom_range(16'h6000, 16'hFFFF));
      end
    endcase
    send_access(k, a, v);
  endtask

  // window edges, every register, both halves' latch triggers
  task automatic run_directed();
    send_access(KIND_CPU_RD, 16'h0000, 8'h00);
    send_access(KIND_CPU_RD, 16'h5FFF, 8'hFF);
    send_access(KIND_CPU_RD, 16'h6000, 8'h00);
    send_access(KIND_CPU_RD, 16'h8000, 8'h00);
    send_access(KIND_CPU_RD, 16'h9FFF, 8'h00);
    send_access(KIND_CPU_RD, 16'hBFFF, 8'h00);
    send_access(KIND_CPU_RD, 16'hC000, 8'h00);
    send_access(KIND_CPU_RD, 16'hFFFF, 8'h00);
    send_access(KIND_CPU_WR, 16'h7FFF, 8'hFF);
    send_access(KIND_CPU_WR, 16'h8000, 8'hAA);
    send_access(KIND_CPU_WR, 16'hA000, 8'hFF);
    send_access(KIND_CPU_WR, 16'hB123, 8'hFF);
    send_access(KIND_CPU_WR, 16'hC000, 8'h1E);
    send_access(KIND_CPU_WR, 16'hD000, 8'h11);
    send_access(KIND_CPU_WR, 16'hE000, 8'h13);
    send_access(KIND_CPU_WR, 16'hF000, 8'h00);
    send_access(KIND_CPU_RD, 16'h8000, 8'h00);
    send_access(KIND_PPU_RD, 16'h0FD8, 8'h00);
    send_access(KIND_PPU_RD, 16'h0FE8, 8'h00);
    send_access(KIND_PPU_RD, 16'h0000, 8'h00);
    send_access(KIND_PPU_RD, 16'h1FDF, 8'h00);
    send_access(KIND_PPU_RD, 16'h1FE8, 8'h00);
    send_access(KIND_PPU_RD, 16'h1FFF, 8'h00);
    send_access(KIND_PPU_RD, 16'h2000, 8'h00);
    send_access(KIND_PPU_WR, 16'h0FD8, 8'h5A);
    send_access(KIND_PPU_WR, 16'hFFFF, 8'hA5);
    send_access(KIND_CPU_WR, 16'hFFFF, 8'hFF);
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_CPU_RD;
    in_if.bus_address = '0;
    in_if.write_value = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    drain_check       = 1'b0;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: load_setting(32'd16, 32'd32, 32'd0, 32'd0);
        1: load_setting(32'd6, 32'd5, 32'd1, 32'd1);
        2: load_setting(32'd4, 32'd1, 32'd1, 32'd0);
        3: load_setting(32'd0, 32'd0, 32'd0, 32'd1);
        4: load_setting(32'd31, 32'd63, 32'd1, 32'd1);
        default: load_setting($urandom, $urandom, $urandom, $urandom);
      endcase
      if (phase == 1) run_directed();
      if (phase == PhaseCount - 1) calm = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        // keep offering while the output is held off so the input backs up
        if (phase == 2 && i == 40) hold_req = 1'b1;
        if (phase == 3 && i == 60) begin
          release_bus();
          wait (outstanding == 0);
        end
        send_random();
      end
      settle();
    end

    @(negedge clk) drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Ran %0d bus accesses across %0d register settings, clamped counts included,",
             accesses, PhaseCount);
    $display("with random stalls on both sides, one long output hold-off and one full drain.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lcbm_pkg.sv
hdl/lcbm_in_if.sv
hdl/lcbm_out_if.sv
hdl/lcbm_cfg_regs.sv
hdl/lcbm_mod_unit.sv
hdl/latched_chr_bank_mapper_core.sv
tb/sv/lcbm_mapping_checker.sv
tb/sv/latched_chr_bank_mapper_core_tb.sv
